### sv/ovlt_pkg.sv
package ovlt_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int FLD_W = 5;

	localparam logic [1:0] KIND_APPEND = 2'd0;
	localparam logic [1:0] KIND_DELETE = 2'd1;
	localparam logic [1:0] KIND_SEARCH = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [FLD_W-1:0] position;
		logic [FLD_W-1:0] entry_count;
	} res_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic cap;   // register compare against incoming key
		logic del;   // delete commit: cells at/after the hit take neighbor data
		logic load;  // append commit: this cell takes the key
		logic live;  // cell holds a valid entry
	} cell_ctl_t;

	// count-sized value reported in a 5-bit field
	function automatic logic [FLD_W-1:0] to_field(input logic [CNT_W-1:0] v);
		logic [31:0] tmp;
		tmp = 32'(v);
		return tmp[FLD_W-1:0];
	endfunction

endpackage

### sv/ovlt_cell.sv
module ovlt_cell import ovlt_pkg::*; (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic signed [31:0] cmp_key,
	input  logic signed [31:0] load_data,
	input  logic signed [31:0] next_data,
	input  logic               seen_in,
	output logic signed [31:0] data,
	output logic               seen_out,
	output logic               first_hit
);

	logic signed [31:0] data_q;
	logic               match_q;
	logic               hit;

	assign hit       = match_q & ctl.live;
	assign seen_out  = seen_in | hit;
	assign first_hit = hit & ~seen_in;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			match_q <= (data_q == cmp_key);
		end
		if (ctl.del && seen_out) begin
			data_q <= next_data;
		end else if (ctl.load) begin
			data_q <= load_data;
		end
	end

endmodule

### sv/ordered_value_list_table_core.sv
// Channel | Dir | Handshake             | Payload
// request | in  | in_valid / in_ready   | in_req  (req_t: kind, item_value)
// result  | out | out_valid / out_ready | out_res (res_t: status, position, entry_count)
//
// Per request: all cells compare against the key at acceptance,
// then the hit prefix ripples along the cell row and the commit shifts or loads.
// One request in flight; the next is taken once the previous result is registered.
// The commit stalls while an earlier result still waits for out_ready.
// arst_n clears the count, state and result valid; cell data is not reset.
module ordered_value_list_table_core import ovlt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [1:0]         kind_q;
	logic signed [31:0] key_q;
	logic               res_valid_q;
	res_t               res_q;

	cell_ctl_t          ctl [DEPTH];
	logic signed [31:0] cdata [DEPTH];
	logic signed [31:0] cnext [DEPTH];
	logic [DEPTH:0]     seen;
	logic [DEPTH-1:0]   first_hit;

	logic             accept, go, full, any_hit;
	logic [IDX_W-1:0] hit_idx;
	logic [CNT_W-1:0] hit_pos;
	logic [CNT_W-1:0] count_d;
	res_t             res_d;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign go        = (state_q == S_EXEC) & (~res_valid_q | out_ready);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign any_hit   = seen[DEPTH];
	assign out_valid = res_valid_q;
	assign out_res   = res_q;
	assign seen[0]   = 1'b0;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			if (g == DEPTH - 1) begin : g_last
				assign cnext[g] = cdata[g];
			end else begin : g_mid
				assign cnext[g] = cdata[g+1];
			end

			always_comb begin
				ctl[g].cap  = accept;
				ctl[g].del  = go && (kind_q == KIND_DELETE);
				ctl[g].load = go && (kind_q == KIND_APPEND) && (count_q == CNT_W'(g));
				ctl[g].live = (CNT_W'(g) < count_q);
			end

			ovlt_cell u_cell (
				.clk       (clk),
				.ctl       (ctl[g]),
				.cmp_key   (in_req.item_value),
				.load_data (key_q),
				.next_data (cnext[g]),
				.seen_in   (seen[g]),
				.data      (cdata[g]),
				.seen_out  (seen[g+1]),
				.first_hit (first_hit[g])
			);
		end
	endgenerate

	// first_hit is one-hot or zero
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
		hit_pos = CNT_W'(hit_idx) + CNT_W'(1);
	end

	always_comb begin
		count_d        = count_q;
		res_d.status   = ST_DONE;
		res_d.position = '0;
		case (kind_q)
			KIND_APPEND: begin
				if (full) begin
					res_d.status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			KIND_DELETE: begin
				if (any_hit) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			KIND_SEARCH: begin
				if (any_hit) begin
					res_d.position = to_field(hit_pos);
				end else begin
					res_d.status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
		res_d.entry_count = to_field(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			kind_q      <= KIND_APPEND;
			key_q       <= '0;
			res_q       <= '0;
		end else begin
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q  <= in_req.kind;
						key_q   <= in_req.item_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						res_q   <= res_d;
						count_q <= count_d;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_res.entry_count == to_field(count_q)))
		else $error("reported count differs from held count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_res.status == ST_FULL) |-> full)
		else $error("full status with room left");

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> $onehot0(first_hit))
		else $error("more than one first match");

endmodule

### verif/ordered_value_list_table_core_tb.sv
module ordered_value_list_table_core_tb;
	import ovlt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// kind code with no operation behind it
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	res_t out_res;

	req_t queued_requests[$];
	res_t predicted_replies[$];
	logic signed [31:0] shadow_list[$];
	logic signed [31:0] value_pool[8];

	int unsigned send_idle_pct = 12;
	int unsigned recv_idle_pct = 67;
	int phase_no = 0;
	logic hold_off = 1'b0;
	int err_count = 0;

	ordered_value_list_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_req(in_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res(out_res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// apply one request to the shadow list and return the reply it should produce
	function automatic res_t apply_list_op(input req_t r);
		res_t res;
		int hit;
		res = '0;
		res.status = ST_DONE;
		hit = -1;
		for (int i = 0; i < shadow_list.size(); i++)
			if (hit < 0 && shadow_list[i] == r.item_value)
				hit = i;
		case (r.kind)
			KIND_APPEND: begin
				if (shadow_list.size() >= DEPTH)
					res.status = ST_FULL;
				else
					shadow_list.push_back(r.item_value);
			end
			KIND_DELETE: begin
				if (hit < 0)
					res.status = ST_NOT_FOUND;
				else
					shadow_list.delete(hit);
			end
			KIND_SEARCH: begin
				if (hit < 0)
					res.status = ST_NOT_FOUND;
				else
					res.position = FLD_W'(hit + 1);
			end
			default: ;
		endcase
		res.entry_count = FLD_W'(shadow_list.size());
		return res;
	endfunction

	task automatic add_request(input logic [1:0] kind, input logic signed [31:0] value);
		req_t r;
		r.kind = kind;
		r.item_value = value;
		queued_requests.push_back(r);
	endtask

	task automatic refill_pool();
		for (int i = 0; i < 8; i++)
			value_pool[i] = $urandom;
		case ($urandom_range(3))
			0: value_pool[0] = 32'sh8000_0000;
			1: value_pool[0] = 32'sh7fff_ffff;
			2: value_pool[0] = 32'sh0000_0000;
			default: value_pool[0] = -32'sd1;
		endcase
	endtask

	// blocks of requests over a small value pool so that deletes and searches hit;
	// the append weight varies per block so the list swings between empty and full
	task automatic gen_list_traffic(input int n_ops);
		int done_ops;
		int in_block;
		int w_app;
		int r;
		logic [1:0] kind;
		logic signed [31:0] value;
		done_ops = 0;
		in_block = 0;
		w_app = 70;
		refill_pool();
		while (done_ops < n_ops) begin
			if (in_block == 40) begin
				in_block = 0;
				w_app = $urandom_range(20, 70);
				if ($urandom_range(1) == 0)
					refill_pool();
			end
			r = $urandom_range(99);
			if (r < 3)
				kind = KIND_UNUSED;
			else if (r < 3 + w_app)
				kind = KIND_APPEND;
			else if (r < 3 + w_app + (97 - w_app) / 2)
				kind = KIND_DELETE;
			else
				kind = KIND_SEARCH;
			if ($urandom_range(99) < 15)
				value = $urandom;
			else
				value = value_pool[$urandom_range(7)];
			add_request(kind, value);
			in_block++;
			if (kind != KIND_UNUSED)
				done_ops++;
		end
	endtask

	task automatic wait_drained();
		while (queued_requests.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// driver: one request on the bus at a time, held until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predicted_replies.push_back(apply_list_op(in_req));
			if (!in_valid || in_ready) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_req <= queued_requests.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each reply with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		res_t exp_res;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (predicted_replies.size() == 0) begin
					$error("reply with no request pending: status %0d position %0d count %0d",
						out_res.status, out_res.position, out_res.entry_count);
					err_count++;
				end else begin
					exp_res = predicted_replies.pop_front();
					if (out_res.status !== exp_res.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							exp_res.status, out_res.status);
						err_count++;
					end
					if (out_res.position !== exp_res.position) begin
						$error("position mismatch: expected %0d, actual %0d",
							exp_res.position, out_res.position);
						err_count++;
					end
					if (out_res.entry_count !== exp_res.entry_count) begin
						$error("entry_count mismatch: expected %0d, actual %0d",
							exp_res.entry_count, out_res.entry_count);
						err_count++;
					end
				end
			end
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// long receiver stall so the block backs up and stops taking requests
	initial begin
		wait (phase_no == 3);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#400_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		phase_no = 1;
		// empty list cases
		add_request(KIND_SEARCH, 32'sd0);
		add_request(KIND_DELETE, 32'sd5);
		// extremes, with a duplicate of the max value
		add_request(KIND_APPEND, 32'sh8000_0000);
		add_request(KIND_APPEND, 32'sh7fff_ffff);
		add_request(KIND_APPEND, 32'sd0);
		add_request(KIND_APPEND, -32'sd1);
		add_request(KIND_APPEND, 32'sh7fff_ffff);
		add_request(KIND_SEARCH, 32'sh8000_0000);
		add_request(KIND_SEARCH, 32'sh7fff_ffff);
		add_request(KIND_SEARCH, -32'sd1);
		add_request(KIND_SEARCH, 32'sd1234);
		// delete takes the first of the duplicates; the later one moves up
		add_request(KIND_DELETE, 32'sh7fff_ffff);
		add_request(KIND_SEARCH, 32'sh7fff_ffff);
		add_request(KIND_DELETE, 32'sh7fff_ffff);
		add_request(KIND_DELETE, -32'sd1);
		add_request(KIND_DELETE, 32'sd77);
		add_request(KIND_UNUSED, -32'sd1);
		add_request(KIND_SEARCH, 32'sd0);
		add_request(KIND_DELETE, 32'sh8000_0000);
		add_request(KIND_SEARCH, 32'sd0);
		add_request(KIND_DELETE, 32'sd0);
		add_request(KIND_SEARCH, 32'sd0);
		gen_list_traffic(480);
		wait_drained();

		phase_no = 2;
		send_idle_pct = 67;
		recv_idle_pct = 12;
		gen_list_traffic(480);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		gen_list_traffic(490);
		phase_no = 3;
		wait_drained();

		while (predicted_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
